/* src/irc_pkg.sv */
package irc_pkg;

  // Table geometry
  localparam int SLOTS          = 64;
  localparam int SLOT_W         = 6;
  localparam int INODE_W        = 15;
  localparam int CNT_W          = 16;
  localparam int BLK_W          = 10;
  localparam int OFF_W          = 12;
  localparam int STATUS_W       = 3;

  // Disk layout
  localparam int INODES_PER_BLK = 64;
  localparam int INODE_BYTES    = 64;
  localparam int FIRST_BLK      = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Request codes
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_LOADED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_WRITEBACK = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Request token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic                vld;
    logic                func;
    logic [INODE_W-1:0]  num;
    logic [SLOT_W-1:0]   idx;
    logic                found;      // get: live match, put: live target slot
    logic [SLOT_W-1:0]   slot;
    logic [INODE_W-1:0]  id;
    logic [CNT_W-1:0]    refs;
    logic                free;       // get: a free slot seen
    logic [SLOT_W-1:0]   free_slot;
  } tok_t;

  // Broadcast write that claims a free slot
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [INODE_W-1:0] id;
  } wr_t;

  function automatic logic [BLK_W-1:0] inode_block(input logic [INODE_W-1:0] id);
    return BLK_W'((id / INODES_PER_BLK) + FIRST_BLK);
  endfunction

  function automatic logic [OFF_W-1:0] inode_offset(input logic [INODE_W-1:0] id);
    return OFF_W'((id % INODES_PER_BLK) * INODE_BYTES);
  endfunction

endpackage

/* src/irc_cell.sv */
module irc_cell
  import irc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] my_slot,
  input  wr_t               wr,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [INODE_W-1:0] id_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  tok_t               tok_r;
  tok_t               tok_nxt;

  // Examine the passing token against this slot
  always_comb begin
    tok_nxt = tok_i;
    cnt_nxt = cnt_r;
    if (tok_i.vld) begin
      if (tok_i.func == FUNC_GET) begin
        if (!tok_i.found && cnt_r != '0 && id_r == tok_i.num) begin
          cnt_nxt       = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
          tok_nxt.found = 1'b1;
          tok_nxt.slot  = my_slot;
          tok_nxt.id    = id_r;
          tok_nxt.refs  = cnt_nxt;
        end
        if (!tok_i.free && cnt_r == '0) begin
          tok_nxt.free      = 1'b1;
          tok_nxt.free_slot = my_slot;
        end
      end else if (tok_i.idx == my_slot && cnt_r != '0) begin
        cnt_nxt       = cnt_r - CNT_W'(1);
        tok_nxt.found = 1'b1;
        tok_nxt.slot  = my_slot;
        tok_nxt.id    = id_r;
        tok_nxt.refs  = cnt_nxt;
      end
    end
    // Claim this slot on a load
    if (wr.en && wr.slot == my_slot) begin
      cnt_nxt = CNT_W'(1);
    end
  end

  // Hold slot count and advance the token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_nxt;
    end
  end

  // Inode number store, no reset
  always_ff @(posedge clk) begin
    if (wr.en && wr.slot == my_slot) begin
      id_r <= wr.id;
    end
  end

  assign tok_o = tok_r;

endmodule

/* src/inode_refcount_cache_table.sv */
// Channel  Ports                                              Dir
// in       in_valid, in_stall, in_func, in_inode_number,      in (stall out)
//          in_slot_index
// out      out_valid, out_stall, out_status, out_slot,        out (stall in)
//          out_inode_id, out_disk_block, out_byte_offset,
//          out_references
//
// A request walks the row of 64 slot cells at one cell per cycle, then
// the S_DONE state settles the result and any slot claim.
// in_stall is high from acceptance until the result is written to the
// output register, so no new request is taken before then; a
// new request is taken while that result still waits.
// A stalled output holds the finished request in its final stage.
// Reset (rst_n low, synchronous) clears all reference counts.
module inode_refcount_cache_table
  import irc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [INODE_W-1:0]  in_inode_number,
  input  logic [SLOT_W-1:0]   in_slot_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [INODE_W-1:0]  out_inode_id,
  output logic [BLK_W-1:0]    out_disk_block,
  output logic [OFF_W-1:0]    out_byte_offset,
  output logic [CNT_W-1:0]    out_references
);

  state_t              state_r;
  state_t              state_nxt;
  tok_t                tok_launch;
  tok_t                chain [SLOTS+1];
  logic [SLOTS-1:0]    tok_vld;
  tok_t                fin_r;
  wr_t                 wr;
  logic                out_free;
  logic                res_load;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [INODE_W-1:0]  id_r, id_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [CNT_W-1:0]    refs_r, refs_nxt;

  // Launch a fresh token on accept
  always_comb begin
    tok_launch         = '0;
    tok_launch.vld     = in_valid && !in_stall;
    tok_launch.func    = in_func;
    tok_launch.num     = in_inode_number;
    tok_launch.idx     = in_slot_index;
  end

  assign chain[0] = tok_launch;

  // Row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    irc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_slot (SLOT_W'(i)),
      .wr      (wr),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
    assign tok_vld[i] = chain[i+1].vld;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Next state, result and slot claim
  always_comb begin
    state_nxt  = state_r;
    res_load   = 1'b0;
    wr         = '0;
    wr.slot    = fin_r.free_slot;
    wr.id      = fin_r.num;
    status_nxt = STAT_IGNORED;
    slot_nxt   = '0;
    id_nxt     = '0;
    blk_nxt    = '0;
    off_nxt    = '0;
    refs_nxt   = '0;

    if (fin_r.func == FUNC_GET) begin
      id_nxt = fin_r.num;
      if (fin_r.found) begin
        status_nxt = STAT_HIT;
        slot_nxt   = fin_r.slot;
        refs_nxt   = fin_r.refs;
      end else if (fin_r.free) begin
        status_nxt = STAT_LOADED;
        slot_nxt   = fin_r.free_slot;
        blk_nxt    = inode_block(fin_r.num);
        off_nxt    = inode_offset(fin_r.num);
        refs_nxt   = CNT_W'(1);
      end else begin
        status_nxt = STAT_FULL;
      end
    end else begin
      slot_nxt = fin_r.idx;
      if (!fin_r.found) begin
        status_nxt = STAT_IGNORED;
      end else if (fin_r.refs == '0) begin
        status_nxt = STAT_WRITEBACK;
        id_nxt     = fin_r.id;
        blk_nxt    = inode_block(fin_r.id);
        off_nxt    = inode_offset(fin_r.id);
      end else begin
        status_nxt = STAT_RELEASED;
        id_nxt     = fin_r.id;
        refs_nxt   = fin_r.refs;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (chain[0].vld) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[SLOTS].vld) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load  = 1'b1;
          wr.en     = (fin_r.func == FUNC_GET) && !fin_r.found && fin_r.free;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture finished token and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN && chain[SLOTS].vld) begin
      fin_r <= chain[SLOTS];
    end
    if (res_load) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      id_r     <= id_nxt;
      blk_r    <= blk_nxt;
      off_r    <= off_nxt;
      refs_r   <= refs_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_inode_id    = id_r;
  assign out_disk_block  = blk_r;
  assign out_byte_offset = off_r;
  assign out_references  = refs_r;

  // Only one token is ever in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one token in the cell row");

  // An accepting block has an empty row
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (tok_vld == '0))
    else $error("token in row while accepting");

  // A new result beat comes only from the final stage
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result beat without a finished request");

  // A slot claim only follows a get that missed
  a_claim: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_DONE && fin_r.func == FUNC_GET && !fin_r.found))
    else $error("slot claim outside a get miss");

endmodule
